>>> rtl/dto_pkg.sv
// Shared types and constants for the device table with oldest-entry eviction.
// Used by dto_ctrl, dto_dpath and device_table_oldest_eviction_core.
package dto_pkg;

  localparam logic [31:0] DEFAULT_TIMEOUT_MS = 32'd30000;

  // register index, taken from byte address bit 2
  localparam logic REG_ONLINE_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY_KEY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] device_key;
    logic [47:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic        was_present;
    logic        evicted;
    logic        online;
    logic [47:0] last_seen;
    logic [4:0]  occupied_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic update;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/dto_ctrl.sv
// Sequencer for the device table: accept, scan, drain, update, finish.
// Depends on dto_pkg for the state, command and status types.
module dto_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dto_pkg::dp_stat_t   stat,
  output dto_pkg::ctrl_cmd_t  cmd
);

  dto_pkg::state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dto_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      dto_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stat.needs_scan ? dto_pkg::S_SCAN : dto_pkg::S_UPDATE;
        end
      end
      dto_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = dto_pkg::S_DRAIN;
        end
      end
      // last read word is compared here
      dto_pkg::S_DRAIN: begin
        state_nxt = dto_pkg::S_UPDATE;
      end
      dto_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = dto_pkg::S_FINISH;
      end
      dto_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dto_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dto_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dto_dpath.sv
// Datapath of the device table: key/time memories, valid bits, scan compare,
// slot selection, online check and the output register. Depends on dto_pkg.
module dto_dpath #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dto_pkg::in_word_t   in_data,
  input  logic [31:0]         timeout_lim,
  input  dto_pkg::ctrl_cmd_t  cmd,
  output dto_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_stall,
  output dto_pkg::out_word_t  out_data
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int KW = 8 * KEY_BYTES;
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

  logic [KW-1:0] key_mem [MAX_SLOTS];
  logic [47:0]   time_mem [MAX_SLOTS];

  logic [MAX_SLOTS-1:0] valid_r;
  logic [CW-1:0]        cnt_r;

  logic [1:0]    cmd_r;
  logic [KW-1:0] key_r;
  logic [47:0]   now_r;
  logic          scanned_r;

  logic [SW-1:0] addr_r, rd_idx_r;
  logic          rd_vld_r;
  logic [KW-1:0] key_q;
  logic [47:0]   time_q;

  logic          hit_r, free_found_r, old_found_r;
  logic [SW-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [47:0]   hit_time_r, old_time_r;

  logic [SW-1:0] sel_r, sel;
  logic          evict_r;
  logic [47:0]   diff_r;
  logic          le_r, tnz_r;

  logic          out_valid_r;
  dto_pkg::out_word_t out_r, out_nxt;

  logic          is_touch, is_lookup, rd_slot_valid, in_key_nz;
  logic [31:0]   timeout_eff;
  logic [SW+3:0] idx_ext;
  logic [CW+4:0] cnt_ext;
  logic [SW-1:0] idx_pick;

  assign is_touch  = (cmd_r == dto_pkg::CMD_TOUCH);
  assign is_lookup = (cmd_r == dto_pkg::CMD_LOOKUP);
  assign in_key_nz = (in_data.device_key[KW-1:0] != '0);

  assign stat.needs_scan = ((in_data.command == dto_pkg::CMD_TOUCH) ||
                            (in_data.command == dto_pkg::CMD_LOOKUP)) && in_key_nz;
  assign stat.scan_last  = (addr_r == LAST_SLOT);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign rd_slot_valid = valid_r[rd_idx_r];
  assign sel = hit_r ? hit_idx_r : (free_found_r ? free_idx_r : old_idx_r);
  assign timeout_eff = (timeout_lim == '0) ? dto_pkg::DEFAULT_TIMEOUT_MS : timeout_lim;

  // memory ports: one registered read for the scan, one write in update
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      key_q  <= key_mem[addr_r];
      time_q <= time_mem[addr_r];
    end
    if (cmd.update && scanned_r && is_touch) begin
      time_mem[sel] <= now_r;
      if (!hit_r) begin
        key_mem[sel] <= key_r;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.update) begin
        if (cmd_r == dto_pkg::CMD_CLEAR) begin
          valid_r <= '0;
          cnt_r   <= '0;
        end else if (scanned_r && is_touch && !hit_r) begin
          valid_r[sel] <= 1'b1;
          if (free_found_r) begin
            cnt_r <= CW'(cnt_r + 1'b1);
          end
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture, scan compare and update payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r        <= in_data.command;
      key_r        <= in_data.device_key[KW-1:0];
      now_r        <= in_data.now_ms;
      scanned_r    <= stat.needs_scan;
      addr_r       <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
    end else begin
      if (cmd.scan_rd) begin
        rd_idx_r <= addr_r;
        addr_r   <= SW'(addr_r + 1'b1);
      end
      if (rd_vld_r) begin
        // first matching valid slot
        if (rd_slot_valid && (key_q == key_r) && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= rd_idx_r;
          hit_time_r <= time_q;
        end
        // first free slot
        if (!rd_slot_valid && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
        // oldest valid slot, strict compare keeps the lowest index on ties
        if (rd_slot_valid && (!old_found_r || (time_q < old_time_r))) begin
          old_found_r <= 1'b1;
          old_idx_r   <= rd_idx_r;
          old_time_r  <= time_q;
        end
      end
    end
    if (cmd.update) begin
      sel_r   <= sel;
      evict_r <= !hit_r && !free_found_r;
      diff_r  <= now_r - hit_time_r;
      le_r    <= (now_r <= hit_time_r);
      tnz_r   <= (hit_time_r != '0);
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  // result word
  always_comb begin
    out_nxt  = '0;
    idx_pick = '0;
    if (scanned_r) begin
      if (is_touch) begin
        idx_pick            = sel_r;
        out_nxt.was_present = hit_r;
        out_nxt.evicted     = evict_r;
        out_nxt.last_seen   = now_r;
      end else if (hit_r) begin
        idx_pick            = hit_idx_r;
        out_nxt.was_present = 1'b1;
        out_nxt.last_seen   = hit_time_r;
        out_nxt.online      = tnz_r && (le_r || (diff_r <= {16'd0, timeout_eff}));
      end else begin
        out_nxt.status = dto_pkg::STAT_NOT_FOUND;
      end
    end else if (is_touch || is_lookup) begin
      out_nxt.status = dto_pkg::STAT_EMPTY_KEY;
    end
    idx_ext                = {4'd0, idx_pick};
    cnt_ext                = {5'd0, cnt_r};
    out_nxt.slot_index     = idx_ext[3:0];
    out_nxt.occupied_count = cnt_ext[4:0];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/device_table_oldest_eviction_core.sv
// Top level of the device table with oldest-entry eviction.
// Holds the timeout register and joins dto_ctrl and dto_dpath; uses dto_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries a command word (touch,
//   lookup or clear), a packed device key and the current time. The output
//   channel out_valid/out_stall/out_data returns exactly one result word per
//   command. The APB port sets online_timeout_ms at byte address 0 (0 acts
//   as 30000); pready is always high and reads return the register.
// Sequence:
//   Touch and lookup with a nonzero key scan all MAX_SLOTS entries through
//   one registered memory read port, one slot per cycle, then pass through
//   drain, update and finish; the next word is taken only back in idle.
//   Clear, empty-key and unused commands skip the scan and drain states.
// Reset:
//   Synchronous active-low rst_n empties the table (valid bits cleared),
//   drops any pending result and loads the timeout default of 30000.
// Backpressure:
//   A finished result holds in the output register while out_stall is high;
//   the block still accepts and scans the next word, then waits to deliver.
module device_table_oldest_eviction_core #(
  parameter int MAX_SLOTS = 16,
  parameter int KEY_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dto_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dto_pkg::out_word_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] timeout_r;
  dto_pkg::ctrl_cmd_t cmd;
  dto_pkg::dp_stat_t  stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == dto_pkg::REG_ONLINE_TIMEOUT) ? timeout_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= dto_pkg::DEFAULT_TIMEOUT_MS;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == dto_pkg::REG_ONLINE_TIMEOUT)) begin
      timeout_r <= pwdata;
    end
  end

  dto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dto_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .timeout_lim (timeout_r),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // one word at a time: an accepted word blocks the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // eviction only happens with a full table
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted) |-> (out_data.occupied_count == 5'(MAX_SLOTS)))
    else $error("eviction reported with free slots");

  // online implies a successful lookup
  a_online_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.online) |->
      (out_data.was_present && (out_data.status == dto_pkg::STAT_OK)))
    else $error("online reported for a missing device");
`endif

endmodule
